[design/fts_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the FOC transform block.
// Used by foc_transform_svpwm; has no dependencies of its own.
package fts_pkg;

  // Fixed-point format of samples and duties.
  localparam int SampleWidth = 16;
  localparam int Frac        = SampleWidth - 1;

  // Sine table geometry: full-wave depth, quarter-wave size and its index width.
  localparam int SineTableDepth = 1024;
  localparam int IdxBits        = $clog2(SineTableDepth);
  localparam int QBits          = IdxBits - 2;
  localparam int QSize          = 1 << QBits;

  // Q30 constants for products with 1/sqrt3, 2/sqrt3 and sqrt3.
  localparam logic signed [31:0] KInvSqrt3    = 32'sd619925131;
  localparam logic signed [31:0] KTwoInvSqrt3 = 32'sd1239850262;
  localparam logic signed [31:0] KSqrt3       = 32'sd1859775393;

  // Odd polynomial coefficients for sin(pi/2 * x), Q30.
  localparam longint unsigned CA1 = 64'd1686629713;
  localparam longint unsigned CA3 = 64'd693598668;
  localparam longint unsigned CA5 = 64'd85569306;
  localparam longint unsigned CA7 = 64'd5026995;
  localparam longint unsigned CA9 = 64'd172272;

  // Register map.
  localparam logic RegSvpwmMode = 1'b0;

  // Duty generation modes.
  localparam logic ModeSextant  = 1'b0;
  localparam logic ModeMidpoint = 1'b1;

  typedef struct packed {
    logic        [15:0] rotor_angle;
    logic signed [15:0] current_a;
    logic signed [15:0] current_b;
    logic signed [15:0] current_c;
    logic signed [15:0] volt_d_cmd;
    logic signed [15:0] volt_q_cmd;
  } fts_in_t;

  typedef struct packed {
    logic signed [15:0] current_d;
    logic signed [15:0] current_q;
    logic        [15:0] duty_a;
    logic        [15:0] duty_b;
    logic        [15:0] duty_c;
  } fts_out_t;

  // Quarter-wave table: entry m-1 holds sin(pi/2 * m / QSize) for m = 1 .. QSize.
  typedef logic [Frac-1:0] qtab_t [0:QSize-1];

  // Evaluates the polynomial at elaboration time to fill the table.
  function automatic qtab_t build_qtab();
    qtab_t            tab;
    longint unsigned  t;
    longint unsigned  u;
    longint unsigned  p;
    longint unsigned  s;
    longint unsigned  v;
    for (int m = 1; m <= QSize; m++) begin
      t = longint'(m) << (30 - QBits);
      u = (t * t) >> 30;
      p = CA7 - ((u * CA9) >> 30);
      p = CA5 - ((u * p) >> 30);
      p = CA3 - ((u * p) >> 30);
      p = CA1 - ((u * p) >> 30);
      s = (t * p) >> 30;
      v = (s + (64'd1 << (29 - Frac))) >> (30 - Frac);
      if (v > ((64'd1 << Frac) - 1)) begin
        v = (64'd1 << Frac) - 1;
      end
      tab[m-1] = v[Frac-1:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTab = build_qtab();

endpackage

[design/foc_transform_svpwm.sv]
// Clarke/Park, inverse Park and SVPWM duty generation in a six-stage pipeline.
// Depends on fts_pkg for payload types, Q30 constants and the sine table.
// Usage: one sample set enters per clock unless the output stalls; its result passes
// the six registers in order. Throughput is one item per cycle without stalls, set
// by the six-register datapath (table lookup, products, sums, constant products,
// sextant or min/max, duty and clamp) that advances as a whole whenever the output
// register is empty or being taken. A stall at the output holds every stage.
// The mode register at byte address 0 selects sextant SVPWM (0) or midpoint
// min/max injection (1); change it only while no request is in flight.
module foc_transform_svpwm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fts_pkg::fts_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fts_pkg::fts_out_t out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import fts_pkg::*;

  localparam int DW = 24;

  typedef enum logic [2:0] {
    SEXT1, SEXT2, SEXT3, SEXT4, SEXT5, SEXT6
  } sext_e;

  // Signed table read for one quadrant and position.
  function automatic logic signed [15:0] sin_lookup(logic [1:0] quad, logic [QBits-1:0] k);
    logic [Frac-1:0] mag;
    if (quad[0]) begin
      mag = QTab[~k];
    end else if (k == '0) begin
      mag = '0;
    end else begin
      mag = QTab[k - QBits'(1)];
    end
    return quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sd32767;
    if (v < -20'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_duty(logic signed [DW-1:0] v);
    if (v < 0) return 16'd0;
    if (v > DW'(65535)) return 16'hFFFF;
    return v[15:0];
  endfunction

  // Configuration register and APB port.
  logic mode_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegSvpwmMode) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeSextant;
    end else if (psel && penable && pwrite && paddr[2] == RegSvpwmMode) begin
      mode_q <= pwdata[0];
    end
  end

  // Pipeline advances when the output register is free or being read.
  logic       adv;
  logic [5:0] v_q;
  assign adv         = !v_q[5] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[4:0], in_valid_i};
    end
  end

  // Stage 1: sine and cosine lookup, phase B minus C.
  logic signed [15:0] s1_sin_q, s1_cos_q, s1_ia_q, s1_vd_q, s1_vq_q;
  logic signed [16:0] s1_diff_q;
  logic [IdxBits-1:0] idx;
  assign idx = in_data_i.rotor_angle[15 -: IdxBits];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sin_q  <= sin_lookup(idx[IdxBits-1 -: 2], idx[QBits-1:0]);
      s1_cos_q  <= sin_lookup(idx[IdxBits-1 -: 2] + 2'd1, idx[QBits-1:0]);
      s1_ia_q   <= in_data_i.current_a;
      s1_vd_q   <= in_data_i.volt_d_cmd;
      s1_vq_q   <= in_data_i.volt_q_cmd;
      s1_diff_q <= 17'(in_data_i.current_b) - 17'(in_data_i.current_c);
    end
  end

  // Stage 2: i_beta and the products with sine and cosine.
  logic signed [16:0] s2_ibeta_q;
  logic signed [15:0] s2_sin_q, s2_cos_q;
  logic signed [31:0] s2_iacs_q, s2_iasn_q, s2_vdcs_q, s2_vqsn_q, s2_vdsn_q, s2_vqcs_q;
  logic signed [48:0] s2_bprod;
  assign s2_bprod = 49'(s1_diff_q) * 49'(KInvSqrt3) + 49'sd536870912;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ibeta_q <= 17'(s2_bprod >>> 30);
      s2_sin_q   <= s1_sin_q;
      s2_cos_q   <= s1_cos_q;
      s2_iacs_q  <= s1_ia_q * s1_cos_q;
      s2_iasn_q  <= s1_ia_q * s1_sin_q;
      s2_vdcs_q  <= s1_vd_q * s1_cos_q;
      s2_vqsn_q  <= s1_vq_q * s1_sin_q;
      s2_vdsn_q  <= s1_vd_q * s1_sin_q;
      s2_vqcs_q  <= s1_vq_q * s1_cos_q;
    end
  end

  // Stage 3: i_beta products and the inverse Park sums.
  logic signed [32:0] s3_ibsn_q, s3_ibcs_q;
  logic signed [31:0] s3_iacs_q, s3_iasn_q;
  logic signed [17:0] s3_al_q, s3_be_q;
  logic signed [33:0] s3_al_sum, s3_be_sum;
  assign s3_al_sum = 34'(s2_vdcs_q) - 34'(s2_vqsn_q) + 34'sd16384;
  assign s3_be_sum = 34'(s2_vdsn_q) + 34'(s2_vqcs_q) + 34'sd16384;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ibsn_q <= 33'(s2_ibeta_q) * 33'(s2_sin_q);
      s3_ibcs_q <= 33'(s2_ibeta_q) * 33'(s2_cos_q);
      s3_iacs_q <= s2_iacs_q;
      s3_iasn_q <= s2_iasn_q;
      s3_al_q   <= 18'(s3_al_sum >>> Frac);
      s3_be_q   <= 18'(s3_be_sum >>> Frac);
    end
  end

  // Stage 4: d/q currents and the constant products of beta.
  logic signed [15:0] s4_id_q, s4_iq_q;
  logic signed [17:0] s4_al_q, s4_third_q;
  logic signed [18:0] s4_x_q, s4_k_q;
  logic               s4_be_neg_q;
  logic signed [34:0] s4_id_sum, s4_iq_sum;
  logic signed [49:0] s4_third_p, s4_x_p, s4_k_p;
  assign s4_id_sum  = 35'(s3_iacs_q) + 35'(s3_ibsn_q) + 35'sd16384;
  assign s4_iq_sum  = 35'(s3_ibcs_q) - 35'(s3_iasn_q) + 35'sd16384;
  assign s4_third_p = 50'(s3_be_q) * 50'(KInvSqrt3) + 50'sd536870912;
  assign s4_x_p     = 50'(s3_be_q) * 50'(KTwoInvSqrt3) + 50'sd536870912;
  assign s4_k_p     = 50'(s3_be_q) * 50'(KSqrt3) + 50'sd536870912;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_id_q     <= sat16(20'(s4_id_sum >>> Frac));
      s4_iq_q     <= sat16(20'(s4_iq_sum >>> Frac));
      s4_al_q     <= s3_al_q;
      s4_be_neg_q <= s3_be_q[17];
      s4_third_q  <= 18'(s4_third_p >>> 30);
      s4_x_q      <= 19'(s4_x_p >>> 30);
      s4_k_q      <= 19'(s4_k_p >>> 30);
    end
  end

  // Stage 5: sextant choice and midpoint common-mode level.
  logic signed [15:0]   s5_id_q, s5_iq_q;
  logic                 s5_mode_q;
  sext_e                s5_sext_q;
  logic signed [DW-1:0] s5_x_q, s5_y_q, s5_z_q, s5_pa_q, s5_pb_q, s5_pc_q, s5_com_q;
  logic signed [DW-1:0] y, z, pa, pb, pc, mx, mn, mm;
  sext_e                sext;

  assign y  = DW'(s4_al_q) - DW'(s4_third_q);
  assign z  = -DW'(s4_al_q) - DW'(s4_third_q);
  assign pa = DW'(s4_al_q) <<< 1;
  assign pb = DW'(s4_k_q) - DW'(s4_al_q);
  assign pc = -DW'(s4_al_q) - DW'(s4_k_q);
  assign mm = mx + mn;

  always_comb begin
    mx = pa;
    mn = pa;
    if (pb > mx) mx = pb;
    if (pc > mx) mx = pc;
    if (pb < mn) mn = pb;
    if (pc < mn) mn = pc;
  end

  always_comb begin
    priority if (!s4_be_neg_q && !s4_al_q[17]) begin
      sext = (y < 0) ? SEXT2 : SEXT1;
    end else if (!s4_be_neg_q) begin
      sext = (z > 0) ? SEXT3 : SEXT2;
    end else if (!s4_al_q[17]) begin
      sext = (z > 0) ? SEXT5 : SEXT6;
    end else begin
      sext = (y < 0) ? SEXT4 : SEXT5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_id_q   <= s4_id_q;
      s5_iq_q   <= s4_iq_q;
      s5_mode_q <= mode_q;
      s5_sext_q <= sext;
      s5_x_q    <= DW'(s4_x_q);
      s5_y_q    <= y;
      s5_z_q    <= z;
      s5_pa_q   <= pa;
      s5_pb_q   <= pb;
      s5_pc_q   <= pc;
      s5_com_q  <= mm >>> 1;
    end
  end

  // Stage 6: duties per mode, clamped, into the output register.
  logic signed [DW-1:0] half, da, db, dc;
  fts_out_t             out_q;
  assign half = DW'(1) <<< Frac;

  always_comb begin
    da = '0;
    db = '0;
    dc = '0;
    if (s5_mode_q == ModeMidpoint) begin
      da = s5_pa_q - s5_com_q + half;
      db = s5_pb_q - s5_com_q + half;
      dc = s5_pc_q - s5_com_q + half;
    end else begin
      unique case (s5_sext_q)
        SEXT1, SEXT4: begin
          da = half - s5_y_q - s5_x_q;
          db = half + s5_y_q - s5_x_q;
          dc = half + s5_y_q + s5_x_q;
        end
        SEXT2, SEXT5: begin
          da = half + s5_z_q - s5_y_q;
          db = half + s5_z_q + s5_y_q;
          dc = half - s5_z_q - s5_y_q;
        end
        SEXT3, SEXT6: begin
          da = half + s5_x_q + s5_z_q;
          db = half - s5_x_q - s5_z_q;
          dc = half + s5_x_q - s5_z_q;
        end
        default: begin
          da = half;
          db = half;
          dc = half;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.current_d <= s5_id_q;
      out_q.current_q <= s5_iq_q;
      out_q.duty_a    <= clamp_duty(da);
      out_q.duty_b    <= clamp_duty(db);
      out_q.duty_c    <= clamp_duty(dc);
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  // A stalled output must hold back new requests.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while output stalled");

  // An accepted request enters the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted request lost at stage one");

  // A stalled pipeline keeps its third stage.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv && v_q[2]) |=> v_q[2])
    else $error("stage dropped during stall");

  // An item in the last internal stage reaches the output when the pipe moves.
  a_reach_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v_q[4]) |=> out_valid_o)
    else $error("result lost before output");
`endif

endmodule
